>>> rtl/snco_pkg.sv
`timescale 1ns / 1ps

package snco_pkg;

	// Default geometry of the oscillator
	localparam int PHASE_BITS_DEF  = 32;
	localparam int TABLE_BITS_DEF  = 8;
	localparam int SAMPLE_BITS_DEF = 16;

	// Field widths of the transactions
	localparam int FREQ_BITS = 16;
	localparam int AMP_BITS  = 16;
	localparam int OUT_BITS  = 16;

	// Configuration port geometry
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 64;
	localparam int PPH_BITS      = 36;
	localparam int DEG_BITS      = 9;

	// Register indexes, taken from address bit 3
	localparam logic REG_PHASE_PER_HZ    = 1'b0;
	localparam logic REG_START_PHASE_DEG = 1'b1;

	localparam logic [PPH_BITS-1:0] PHASE_PER_HZ_RST    = 36'd5864062015;
	localparam logic [DEG_BITS-1:0] START_PHASE_DEG_RST = 9'd0;

	// Degrees in a full turn
	localparam logic [DEG_BITS:0] DEG_PER_TURN = 10'd360;

	// Phase increment product counts turns in units of 2^-48
	localparam int TURN_FRAC_BITS = 48;
	// Split of the phase step register for the narrow multiplier
	localparam int PPH_HALF_BITS = 18;
	// Width of one partial product of frequency and a half step
	localparam int PART_BITS = FREQ_BITS + PPH_HALF_BITS;

	typedef enum logic {
		REQ_TICK    = 1'b0,
		REQ_RESTART = 1'b1
	} snco_req_t;

	typedef struct packed {
		logic [PPH_BITS-1:0] phase_per_hz;
		logic [DEG_BITS-1:0] start_phase_deg;
	} snco_cfg_t;

	// Table construction constants in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;
	localparam longint unsigned TAYLOR_DEN [1:7] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	// Quarter-wave sine entry i of a table with 2^tbits steps, scaled to
	// the peak of a signed sbits sample
	function automatic longint unsigned sine_entry(int idx, int tbits, int sbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned peak;
		longint unsigned e;
		longint          sum;
		x    = (longint'(idx) * HALF_PI_Q30 + (64'd1 << (tbits - 1))) >> tbits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DEN[n];
			if (n[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q30))
			sum = longint'(ONE_Q30);
		peak = (64'd1 << (sbits - 1)) - 64'd1;
		e    = (longint'(sum) * peak + (ONE_Q30 >> 1)) >> 30;
		if (e > peak)
			e = peak;
		return e;
	endfunction

endpackage

>>> rtl/snco_stream_if.sv
`timescale 1ns / 1ps

// Request channel: sample ticks and restarts
interface snco_in_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic                                enable;
	logic [snco_pkg::FREQ_BITS-1:0]      freq_hz;
	logic signed [snco_pkg::AMP_BITS-1:0] amplitude;

	modport source (output valid, req_type, enable, freq_hz, amplitude, input ready);
	modport sink (input valid, req_type, enable, freq_hz, amplitude, output ready);
endinterface

// Result channel: one sample per request
interface snco_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [snco_pkg::OUT_BITS-1:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

>>> rtl/snco_regs.sv
`timescale 1ns / 1ps

module snco_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [snco_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [snco_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [snco_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output snco_pkg::snco_cfg_t                 cfg
);

	logic [snco_pkg::PPH_BITS-1:0] phase_per_hz_q;
	logic [snco_pkg::DEG_BITS-1:0] start_phase_deg_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Take register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_per_hz_q    <= snco_pkg::PHASE_PER_HZ_RST;
			start_phase_deg_q <= snco_pkg::START_PHASE_DEG_RST;
		end else if (wr_en) begin
			unique case (paddr[3])
				snco_pkg::REG_PHASE_PER_HZ:
					phase_per_hz_q <= pwdata[snco_pkg::PPH_BITS-1:0];
				snco_pkg::REG_START_PHASE_DEG:
					start_phase_deg_q <= pwdata[snco_pkg::DEG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero extended
	always_comb begin
		unique case (paddr[3])
			snco_pkg::REG_PHASE_PER_HZ:
				prdata = {{(snco_pkg::APB_DATA_BITS - snco_pkg::PPH_BITS){1'b0}},
					phase_per_hz_q};
			snco_pkg::REG_START_PHASE_DEG:
				prdata = {{(snco_pkg::APB_DATA_BITS - snco_pkg::DEG_BITS){1'b0}},
					start_phase_deg_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.phase_per_hz    = phase_per_hz_q;
	assign cfg.start_phase_deg = start_phase_deg_q;

endmodule

>>> rtl/snco_mul.sv
`timescale 1ns / 1ps

// Shared signed multiplier: frequency partial products and amplitude scaling
module snco_mul #(
	parameter int B_BITS = 19
) (
	input  logic signed [snco_pkg::AMP_BITS:0]          a,
	input  logic signed [B_BITS-1:0]                    b,
	output logic signed [snco_pkg::AMP_BITS+B_BITS:0]   p
);

	localparam int P_BITS = snco_pkg::AMP_BITS + 1 + B_BITS;

	logic signed [P_BITS-1:0] a_ext;
	logic signed [P_BITS-1:0] b_ext;

	// Sign extend both operands to the product width
	assign a_ext = P_BITS'(a);
	assign b_ext = P_BITS'(b);
	assign p     = a_ext * b_ext;

endmodule

>>> rtl/snco_rom.sv
`timescale 1ns / 1ps

// Quarter-wave sine table with a registered read
module snco_rom #(
	parameter int TABLE_BITS  = snco_pkg::TABLE_BITS_DEF,
	parameter int SAMPLE_BITS = snco_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic [TABLE_BITS:0]    addr,
	output logic [SAMPLE_BITS-2:0] data
);

	localparam int QSIZE      = 1 << TABLE_BITS;
	localparam int ENTRY_BITS = SAMPLE_BITS - 1;

	logic [ENTRY_BITS-1:0] rom [0:QSIZE];
	logic [ENTRY_BITS-1:0] data_q;

	// Fill the table at elaboration, one entry per quarter-turn step
	for (genvar gi = 0; gi <= QSIZE; gi++) begin : g_entry
		assign rom[gi] = ENTRY_BITS'(snco_pkg::sine_entry(gi, TABLE_BITS, SAMPLE_BITS));
	end

	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

	assign data = data_q;

endmodule

>>> rtl/sine_oscillator_nco.sv
`timescale 1ns / 1ps

// Sine oscillator in the style of a direct digital synthesizer. Each request
// transaction is either a sample tick, which advances a PHASE_BITS phase
// accumulator by freq_hz times phase_per_hz (units of 2^-48 turn) and returns
// amplitude times a quarter-wave sine lookup (zero when enable is low; the
// phase still advances), or a restart, which loads start_phase_deg converted
// to a phase and returns zero. Exactly one result transaction follows every
// request. One request is handled at a time: the next is not accepted until
// the last one has left its final step. A tick uses one 17 x N multiplier to
// form the two frequency partial products and the amplitude product in turn,
// with the sine table read registered in between. A restart passes through
// one multiply of the degrees by a fixed reciprocal of 360 and the final step.
// A result that waits on the output register holds the block in its final
// step. The registers sit on an APB port at byte addresses 0 (phase_per_hz,
// 36 bits) and 8 (start_phase_deg); write them only while the block is idle.
module sine_oscillator_nco #(
	parameter int PHASE_BITS  = snco_pkg::PHASE_BITS_DEF,
	parameter int TABLE_BITS  = snco_pkg::TABLE_BITS_DEF,
	parameter int SAMPLE_BITS = snco_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [snco_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [snco_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [snco_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	snco_in_if.sink                             item,
	snco_out_if.source                          result
);

	localparam int B_BITS     = ((SAMPLE_BITS > snco_pkg::PPH_HALF_BITS) ?
		SAMPLE_BITS : snco_pkg::PPH_HALF_BITS) + 1;
	localparam int P_BITS     = snco_pkg::AMP_BITS + 1 + B_BITS;
	localparam int ENTRY_BITS = SAMPLE_BITS - 1;
	localparam int INC_LSB    = snco_pkg::TURN_FRAC_BITS - PHASE_BITS;
	localparam int HALF       = snco_pkg::PPH_HALF_BITS;
	localparam int PART       = snco_pkg::PART_BITS;
	localparam int SUM_BITS   = snco_pkg::TURN_FRAC_BITS;

	// Degrees to phase: multiply by 2^(PHASE_BITS+RECIP_SHIFT)/360 rounded up,
	// then drop RECIP_SHIFT bits; the extra fraction bits keep the quotient
	// exact for every degree value below one turn
	localparam int RECIP_SHIFT = 14;
	localparam int RECIP_BITS  = PHASE_BITS + 6;
	localparam int DPROD_BITS  = RECIP_BITS + snco_pkg::DEG_BITS;

	localparam logic [RECIP_BITS-1:0]      DEG_RECIP  = RECIP_BITS'(
		((64'd1 << (PHASE_BITS + RECIP_SHIFT)) + 64'(snco_pkg::DEG_PER_TURN) - 64'd1) /
		64'(snco_pkg::DEG_PER_TURN));
	localparam logic signed [P_BITS:0]     ROUND_BIAS = (P_BITS + 1)'(1) <<< (SAMPLE_BITS - 2);
	localparam logic signed [P_BITS:0]     SAT_MAX    = (P_BITS + 1)'(32767);
	localparam logic signed [P_BITS:0]     SAT_MIN    = -(P_BITS + 1)'(32768);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL_HI = 8'b0000_0010,
		ST_SUM    = 8'b0000_0100,
		ST_ADD    = 8'b0000_1000,
		ST_LOOK   = 8'b0001_0000,
		ST_AMP    = 8'b0010_0000,
		ST_DONE   = 8'b0100_0000,
		ST_DIV    = 8'b1000_0000
	} state_t;

	snco_pkg::snco_cfg_t cfg;

	state_t                          state_q;
	logic [PHASE_BITS-1:0]           phase_q;
	logic                            out_valid_q;
	logic signed [snco_pkg::OUT_BITS-1:0] sample_q;

	logic [snco_pkg::FREQ_BITS-1:0]  freq_q;
	logic signed [snco_pkg::AMP_BITS-1:0] amp_q;
	logic                            en_q;
	logic                            restart_q;
	logic signed [P_BITS-1:0]        prod_q;
	logic [PART-1:0]                 lo_q;
	logic [SUM_BITS-1:0]             sum_q;
	logic [snco_pkg::DEG_BITS-1:0]   deg_q;

	logic                            accept;
	logic                            out_free;
	logic signed [snco_pkg::AMP_BITS:0] mul_a;
	logic signed [B_BITS-1:0]        mul_b;
	logic signed [P_BITS-1:0]        mul_p;
	logic [TABLE_BITS-1:0]           tab_k;
	logic [TABLE_BITS:0]             rom_addr;
	logic [ENTRY_BITS-1:0]           rom_data;
	logic signed [SAMPLE_BITS-1:0]   sine_val;
	logic [snco_pkg::DEG_BITS-1:0]   deg_red;
	logic [DPROD_BITS-1:0]           deg_prod;
	logic signed [P_BITS:0]          rnd_sum;
	logic signed [P_BITS:0]          rnd_shr;
	logic signed [snco_pkg::OUT_BITS-1:0] sat_val;

	snco_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	snco_mul #(
		.B_BITS (B_BITS)
	) u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	snco_rom #(
		.TABLE_BITS  (TABLE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign item.ready   = (state_q == ST_IDLE);
	assign accept       = item.valid & item.ready;
	assign out_free     = ~out_valid_q | result.ready;
	assign result.valid = out_valid_q;
	assign result.sample = sample_q;

	// Route operands to the shared multiplier by step
	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				mul_a = {1'b0, item.freq_hz};
				mul_b = B_BITS'({1'b0, cfg.phase_per_hz[HALF-1:0]});
			end
			ST_MUL_HI: begin
				mul_a = {1'b0, freq_q};
				mul_b = B_BITS'({1'b0, cfg.phase_per_hz[snco_pkg::PPH_BITS-1:HALF]});
			end
			default: begin
				mul_a = {amp_q[snco_pkg::AMP_BITS-1], amp_q};
				mul_b = B_BITS'(sine_val);
			end
		endcase
	end

	// Fold the phase into a quarter-wave table address
	assign tab_k    = phase_q[PHASE_BITS-3 -: TABLE_BITS];
	assign rom_addr = phase_q[PHASE_BITS-2] ?
		((TABLE_BITS + 1)'(1) << TABLE_BITS) - {1'b0, tab_k} : {1'b0, tab_k};
	assign sine_val = phase_q[PHASE_BITS-1] ?
		-$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

	// Wrap the start phase into one turn, and scale degrees to a phase
	assign deg_red = ({1'b0, cfg.start_phase_deg} >= snco_pkg::DEG_PER_TURN) ?
		snco_pkg::DEG_BITS'({1'b0, cfg.start_phase_deg} - snco_pkg::DEG_PER_TURN) :
		cfg.start_phase_deg;
	assign deg_prod = DPROD_BITS'(deg_q) * DPROD_BITS'(DEG_RECIP);

	// Round half up, then saturate to the output width
	assign rnd_sum = P_BITS'(prod_q) + ROUND_BIAS;
	assign rnd_shr = rnd_sum >>> (SAMPLE_BITS - 1);
	always_comb begin
		priority if (rnd_shr > SAT_MAX)
			sat_val = snco_pkg::OUT_BITS'(SAT_MAX);
		else if (rnd_shr < SAT_MIN)
			sat_val = snco_pkg::OUT_BITS'(SAT_MIN);
		else
			sat_val = rnd_shr[snco_pkg::OUT_BITS-1:0];
	end

	// Sequence one request through the shared unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.req_type == snco_pkg::REQ_RESTART)
							state_q <= ST_DIV;
						else
							state_q <= ST_MUL_HI;
					end
				end
				ST_MUL_HI: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_ADD;
				ST_ADD: begin
					phase_q <= phase_q + sum_q[INC_LSB +: PHASE_BITS];
					state_q <= ST_LOOK;
				end
				ST_LOOK:   state_q <= ST_AMP;
				ST_AMP:    state_q <= ST_DONE;
				ST_DIV: begin
					phase_q <= deg_prod[RECIP_SHIFT +: PHASE_BITS];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Raise the result in the final step, drop it once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.valid && result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the request fields and the partial results
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					freq_q    <= item.freq_hz;
					amp_q     <= item.amplitude;
					en_q      <= item.enable;
					restart_q <= item.req_type;
					prod_q    <= mul_p;
					deg_q     <= deg_red;
				end
			end
			ST_MUL_HI: begin
				lo_q   <= prod_q[PART-1:0];
				prod_q <= mul_p;
			end
			ST_SUM: begin
				sum_q <= {prod_q[SUM_BITS-HALF-1:0], {HALF{1'b0}}} +
					SUM_BITS'(lo_q);
			end
			ST_AMP: prod_q <= mul_p;
			ST_DONE: begin
				if (out_free)
					sample_q <= (en_q && (restart_q == snco_pkg::REQ_TICK)) ?
						sat_val : '0;
			end
			default: ;
		endcase
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import snco_pkg::*;

	typedef longint unsigned u64_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_ITEMS    = 200;
	localparam int RAND_PHASES    = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int QSTEPS         = 1 << TABLE_BITS_DEF;
	localparam int DIR_ROWS       = 26;

	localparam u64_t Q30_ONE     = 64'd1 << 30;
	localparam u64_t Q30_HALF_PI = 64'd1686629713;
	localparam u64_t SINE_PEAK   = (64'd1 << (SAMPLE_BITS_DEF - 1)) - 64'd1;
	localparam logic [PPH_BITS-1:0] PPH_MAX = '1;

	// One row of the directed sequence: either a register write or a transaction
	typedef struct {
		bit                      is_cfg;
		logic                    cfg_reg;
		u64_t                    cfg_val;
		snco_req_t               req;
		logic                    en;
		logic [FREQ_BITS-1:0]    freq;
		logic signed [AMP_BITS-1:0] amp;
		bit                      typed;
		logic signed [OUT_BITS-1:0] want;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	snco_in_if  item_ch ();
	snco_out_if res_ch ();

	sine_oscillator_nco uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (res_ch)
	);

	// Oscillator model state and register copies
	logic [PHASE_BITS_DEF-1:0] osc_phase;
	logic [PPH_BITS-1:0]       cur_pph;
	logic [DEG_BITS-1:0]       cur_deg;
	int                        quarter_sine [0:QSTEPS];

	logic signed [OUT_BITS-1:0] sample_q [$];
	int                         err_cnt;
	bit                         idle_on;
	int                         hold_req;
	int                         quiet_cycles;

	dir_row_t dir_tab [DIR_ROWS] = '{
		// after reset: disabled, then zero phase
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b1, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'd0, 16'sd32767, 1'b1, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'hFFFF, 16'sd32767, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'hFFFF, 16'sh8000, 1'b0, 16'sd0},
		// disabled tick still advances the phase
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b0, 16'd12345, -16'sd1, 1'b1, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'd1000, 16'sd1, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_RESTART, 1'b1, 16'hFFFF, 16'sd32767, 1'b1, 16'sd0},
		// quarter turn: table end
		'{1'b1, REG_START_PHASE_DEG, 64'd90, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_RESTART, 1'b0, 16'd0, 16'sd0, 1'b1, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'd0, 16'sd32767, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'd0, 16'sh8000, 1'b0, 16'sd0},
		// three quarters: negative peak
		'{1'b1, REG_START_PHASE_DEG, 64'd270, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_RESTART, 1'b0, 16'd0, 16'sd0, 1'b1, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'd0, 16'sd32767, 1'b0, 16'sd0},
		// full turn in degrees folds back to zero
		'{1'b1, REG_START_PHASE_DEG, 64'd360, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_RESTART, 1'b1, 16'd7, 16'sd5, 1'b1, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'd0, 16'sd32767, 1'b1, 16'sd0},
		// largest degree value the register holds
		'{1'b1, REG_START_PHASE_DEG, 64'd511, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_RESTART, 1'b0, 16'd0, 16'sd0, 1'b1, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'd0, 16'sh8000, 1'b0, 16'sd0},
		// step wider than a turn wraps; zero step freezes the phase
		'{1'b1, REG_PHASE_PER_HZ, PPH_MAX, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'hFFFF, 16'sd32767, 1'b0, 16'sd0},
		'{1'b1, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b0, 16'sd0},
		'{1'b0, REG_PHASE_PER_HZ, 64'd0, REQ_TICK, 1'b1, 16'hFFFF, -16'sd32767, 1'b0, 16'sd0},
		'{1'b1, REG_PHASE_PER_HZ, PHASE_PER_HZ_RST, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b0, 16'sd0},
		'{1'b1, REG_START_PHASE_DEG, 64'd0, REQ_TICK, 1'b0, 16'd0, 16'sd0, 1'b0, 16'sd0}
	};

	// Sine in Q30 by a truncated Taylor series up to x^15
	function automatic u64_t q30_sine(input u64_t x);
		u64_t   x2;
		u64_t   term;
		longint acc;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / u64_t'(4 * n * n + 2 * n);
			if (n % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		if (acc > longint'(Q30_ONE))
			acc = longint'(Q30_ONE);
		return u64_t'(acc);
	endfunction

	// Advance the model by one transaction and return the sample it yields
	function automatic logic signed [OUT_BITS-1:0] predict_sample(input snco_req_t req,
			input logic en, input logic [FREQ_BITS-1:0] freq,
			input logic signed [AMP_BITS-1:0] amp);
		u64_t       deg;
		u64_t       inc;
		logic [1:0] quad;
		logic [TABLE_BITS_DEF-1:0] k;
		longint     v;
		longint     r;
		if (req == REQ_RESTART) begin
			deg = u64_t'(cur_deg);
			if (deg >= 360)
				deg = deg - 360;
			osc_phase = PHASE_BITS_DEF'((deg << PHASE_BITS_DEF) / 360);
			return '0;
		end
		inc = (u64_t'(freq) * u64_t'(cur_pph)) >> (TURN_FRAC_BITS - PHASE_BITS_DEF);
		osc_phase = osc_phase + inc[PHASE_BITS_DEF-1:0];
		if (!en)
			return '0;
		quad = osc_phase[PHASE_BITS_DEF-1 -: 2];
		k    = osc_phase[PHASE_BITS_DEF-3 -: TABLE_BITS_DEF];
		v    = quad[0] ? quarter_sine[QSTEPS - int'(k)] : quarter_sine[k];
		if (quad[1])
			v = -v;
		r = (longint'(amp) * v + (64'sd1 << (SAMPLE_BITS_DEF - 2))) >>> (SAMPLE_BITS_DEF - 1);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return OUT_BITS'(r);
	endfunction

	// Offer one transaction, wait for acceptance, queue its expected sample
	task automatic send_item(input snco_req_t req, input logic en,
			input logic [FREQ_BITS-1:0] freq, input logic signed [AMP_BITS-1:0] amp,
			input bit typed, input logic signed [OUT_BITS-1:0] want);
		logic signed [OUT_BITS-1:0] pred;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.req_type  <= req;
		item_ch.enable    <= en;
		item_ch.freq_hz   <= freq;
		item_ch.amplitude <= amp;
		do @(posedge clk); while (!item_ch.ready);
		pred = predict_sample(req, en, freq, amp);
		sample_q.push_back(typed ? want : pred);
	endtask

	// Mostly ticks with random content, some restarts, extremes now and then
	task automatic send_random_item();
		snco_req_t                  req;
		logic                       en;
		logic [FREQ_BITS-1:0]       freq;
		logic signed [AMP_BITS-1:0] amp;
		req = ($urandom_range(0, 19) == 0) ? REQ_RESTART : REQ_TICK;
		en  = ($urandom_range(0, 7) != 0);
		case ($urandom_range(0, 3))
			0: freq = FREQ_BITS'($urandom);
			1: freq = FREQ_BITS'($urandom_range(0, 255));
			2: freq = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: freq = FREQ_BITS'($urandom_range(0, 4095));
		endcase
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: amp = 16'sh8000;
				1: amp = 16'sd32767;
				2: amp = 16'sd0;
				default: amp = -16'sd1;
			endcase
		end else begin
			amp = AMP_BITS'($urandom);
		end
		send_item(req, en, freq, amp, 1'b0, '0);
	endtask

	// Drop valid and wait for every outstanding sample
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write a register, mirror it in the model, and read it back
	task automatic cfg_write(input logic reg_idx, input u64_t val);
		u64_t got;
		u64_t mirror;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_idx == REG_PHASE_PER_HZ)
			cur_pph = val[PPH_BITS-1:0];
		else
			cur_deg = val[DEG_BITS-1:0];
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (reg_idx == REG_PHASE_PER_HZ) begin
			got    = u64_t'(prdata[PPH_BITS-1:0]);
			mirror = u64_t'(cur_pph);
		end else begin
			got    = u64_t'(prdata[DEG_BITS-1:0]);
			mirror = u64_t'(cur_deg);
		end
		if (got != mirror) begin
			$error("register %0d readback: expected %0d, got %0d", reg_idx, mirror, got);
			err_cnt++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: check each sample, stall in bursts, long hold on request
	initial begin
		logic signed [OUT_BITS-1:0] want;
		int                         stall_left;
		int                         hold_left;
		stall_left   = 0;
		hold_left    = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (sample_q.size() == 0) begin
					$error("sample: expected none, got %0d", res_ch.sample);
					err_cnt++;
				end else begin
					want = sample_q.pop_front();
					if (res_ch.sample !== want) begin
						$error("sample: expected %0d, got %0d", want, res_ch.sample);
						err_cnt++;
					end
				end
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin
		u64_t pph_val;
		u64_t deg_val;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		item_ch.valid     = 1'b0;
		item_ch.req_type  = REQ_TICK;
		item_ch.enable    = 1'b0;
		item_ch.freq_hz   = '0;
		item_ch.amplitude = '0;
		err_cnt           = 0;
		hold_req          = 0;
		quiet_cycles      = 0;
		idle_on           = 1'b1;
		osc_phase         = '0;
		cur_pph           = PHASE_PER_HZ_RST;
		cur_deg           = START_PHASE_DEG_RST;

		// Build the quarter-wave table
		for (int i = 0; i <= QSTEPS; i++) begin
			u64_t s;
			u64_t e;
			s = q30_sine((u64_t'(i) * Q30_HALF_PI + u64_t'(QSTEPS / 2)) / u64_t'(QSTEPS));
			e = (s * SINE_PEAK + (Q30_ONE >> 1)) >> 30;
			if (e > SINE_PEAK)
				e = SINE_PEAK;
			quarter_sine[i] = int'(e);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sequence
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].is_cfg) begin
				wait_idle();
				cfg_write(dir_tab[i].cfg_reg, dir_tab[i].cfg_val);
			end else begin
				send_item(dir_tab[i].req, dir_tab[i].en, dir_tab[i].freq, dir_tab[i].amp,
					dir_tab[i].typed, dir_tab[i].want);
			end
		end

		// Random phases, each under its own register setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin pph_val = PHASE_PER_HZ_RST; deg_val = 0; end
				1: begin pph_val = {$urandom_range(0, 15), $urandom}; deg_val = 359; end
				2: begin pph_val = PPH_MAX; deg_val = 360; end
				3: begin pph_val = 0; deg_val = 511; end
				4: begin pph_val = $urandom_range(1, 1 << 20); deg_val = $urandom_range(0, 511); end
				6: begin pph_val = 1; deg_val = 1; end
				default: begin
					pph_val = {$urandom_range(0, 15), $urandom};
					deg_val = $urandom_range(0, 511);
				end
			endcase
			wait_idle();
			cfg_write(REG_PHASE_PER_HZ, pph_val[PPH_BITS-1:0]);
			cfg_write(REG_START_PHASE_DEG, deg_val[DEG_BITS-1:0]);
			idle_on = (ph != RAND_PHASES - 1);
			if (ph == 1)
				hold_req = HOLD_CYCLES;
			repeat (PHASE_ITEMS) send_random_item();
		end

		// Drain and report
		item_ch.valid <= 1'b0;
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sample_q.size() != 0) begin
			$error("sample: %0d expected results never arrived", sample_q.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
